### hdl/i2crpf_pkg.sv
// ----------------------------------------------------------------------------
// I2C register pointer file package
// Shared sizes, event and conversation codes, and the register reset image.
// ----------------------------------------------------------------------------
package i2crpf_pkg;

  // Number of byte registers. The last four hold the ID string at reset.
  localparam int unsigned NUM_REGS  = 29;
  localparam int unsigned REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Width of the pointer and compare helpers (pointer is 8 bits, plus headroom).
  localparam int unsigned PTR_W = 8;
  localparam int unsigned CMP_W = PTR_W + 1;

  typedef enum logic [1:0] {
    EV_ADDRESS = 2'd0,
    EV_DATA    = 2'd1,
    EV_STOP    = 2'd2,
    EV_LOAD    = 2'd3
  } ev_kind_e;

  // Conversation state, one-hot.
  typedef enum logic [2:0] {
    CONV_IDLE  = 3'b001,
    CONV_WRITE = 3'b010,
    CONV_READ  = 3'b100
  } conv_e;

  // Encoded conversation as seen on the result port.
  localparam logic [1:0] CONV_CODE_IDLE  = 2'd0;
  localparam logic [1:0] CONV_CODE_WRITE = 2'd1;
  localparam logic [1:0] CONV_CODE_READ  = 2'd2;

  localparam logic [7:0] ID_CHAR_M = 8'h4D;
  localparam logic [7:0] ID_CHAR_O = 8'h4F;
  localparam logic [7:0] ID_CHAR_D = 8'h44;
  localparam logic [7:0] ID_CHAR_X = 8'h58;

  function automatic logic [1:0] conv_code(conv_e c);
    logic [1:0] code;
    case (c)
      CONV_WRITE: code = CONV_CODE_WRITE;
      CONV_READ:  code = CONV_CODE_READ;
      default:    code = CONV_CODE_IDLE;
    endcase
    return code;
  endfunction

  // Reset image: entry i holds i, the last four spell the ID.
  function automatic logic [7:0] reg_reset_val(int unsigned idx);
    logic [7:0] val;
    if (idx == NUM_REGS - 4) begin
      val = ID_CHAR_M;
    end else if (idx == NUM_REGS - 3) begin
      val = ID_CHAR_O;
    end else if (idx == NUM_REGS - 2) begin
      val = ID_CHAR_D;
    end else if (idx == NUM_REGS - 1) begin
      val = ID_CHAR_X;
    end else begin
      val = idx[7:0];
    end
    return val;
  endfunction

endpackage

### hdl/i2c_slave_register_pointer_file.sv
// ----------------------------------------------------------------------------
// I2C slave register pointer file
// Byte-level slave conversation tracker with a register pointer and a small
// register bank that the sensor side can load.
// ----------------------------------------------------------------------------
// Path: start_i passes the input register, then the result register, to done_o.
// Throughput: one transaction per cycle; busy_o stays low, the block never
//   stalls the sender, and the receiver cannot stall the result.
// Reset (rst_ni low, asynchronous): conversation idle, pointer 0, register
//   bank loaded with its index image and the ID bytes, no result pending.
module i2c_slave_register_pointer_file (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] event_kind_i,
  input  logic       read_not_write_i,
  input  logic [7:0] bus_byte_i,
  input  logic [4:0] load_index_i,
  input  logic [7:0] load_value_i,
  output logic       done_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic       readout_request_o,
  output logic [1:0] conversation_o
);
  import i2crpf_pkg::*;

  // --------------------------------------------------------------------------
  // Input register: captures one transaction per cycle.
  // --------------------------------------------------------------------------
  logic       in_vld_q;
  ev_kind_e   ev_q;
  logic       rnw_q;
  logic [7:0] rx_q;
  logic [4:0] lidx_q;
  logic [7:0] lval_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ev_q   <= ev_kind_e'(event_kind_i);
      rnw_q  <= read_not_write_i;
      rx_q   <= bus_byte_i;
      lidx_q <= load_index_i;
      lval_q <= load_value_i;
    end
  end

  // --------------------------------------------------------------------------
  // Architectural state
  // --------------------------------------------------------------------------
  conv_e      conv_q, conv_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [7:0] bank_q [NUM_REGS];

  // Pointed register; anything at or past the bank end reads as zero.
  logic       ptr_in_range;
  logic [7:0] fetch_val;
  logic [PTR_W-1:0] ptr_inc;

  assign ptr_in_range = {1'b0, ptr_q} < CMP_W'(NUM_REGS);
  assign fetch_val    = ptr_in_range ? bank_q[ptr_q[REG_IDX_W-1:0]] : 8'h00;
  assign ptr_inc      = ptr_q + PTR_W'(1);  // wraps at 8 bits

  // Local load only reaches the data registers, never the ID bytes.
  logic                 load_hit;
  logic [CMP_W-1:0]     lidx_wide;
  logic [REG_IDX_W-1:0] load_addr;

  assign lidx_wide = CMP_W'(lidx_q);
  assign load_hit  = in_vld_q && (ev_q == EV_LOAD) && (lidx_wide < CMP_W'(NUM_REGS - 4));
  assign load_addr = lidx_wide[REG_IDX_W-1:0];

  // --------------------------------------------------------------------------
  // Event decode
  // --------------------------------------------------------------------------
  logic [7:0] tx_d;
  logic       txv_d;
  logic       req_d;

  always_comb begin
    conv_d = conv_q;
    ptr_d  = ptr_q;
    tx_d   = 8'h00;
    txv_d  = 1'b0;
    req_d  = 1'b0;
    if (in_vld_q && (ev_q != EV_LOAD)) begin
      case (conv_q)
        CONV_IDLE: begin
          // Any bus event opens a conversation; the R/W bit picks which.
          if (rnw_q) begin
            conv_d = CONV_READ;
            tx_d   = fetch_val;
            txv_d  = 1'b1;
            ptr_d  = ptr_inc;
          end else begin
            conv_d = CONV_WRITE;
          end
        end
        CONV_WRITE: begin
          if (ev_q == EV_STOP) begin
            conv_d = CONV_IDLE;
          end else begin
            ptr_d = rx_q;  // every written byte replaces the pointer
          end
        end
        CONV_READ: begin
          if (ev_q == EV_STOP) begin
            conv_d = CONV_IDLE;
            req_d  = 1'b1;  // ask the sensor side for fresh data
          end else begin
            tx_d  = fetch_val;
            txv_d = 1'b1;
            ptr_d = ptr_inc;
          end
        end
        default: begin
          conv_d = CONV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= CONV_IDLE;
      ptr_q  <= '0;
    end else begin
      conv_q <= conv_d;
      ptr_q  <= ptr_d;
    end
  end

  // Register bank: reset image needed, so it sits on the reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_REGS; i++) begin
        bank_q[i] <= reg_reset_val(i);
      end
    end else if (load_hit) begin
      bank_q[load_addr] <= lval_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: one strobe per accepted transaction.
  // --------------------------------------------------------------------------
  logic       done_q;
  logic [7:0] tx_q;
  logic       txv_q;
  logic       req_q;
  logic [1:0] conv_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      tx_q        <= tx_d;
      txv_q       <= txv_d;
      req_q       <= req_d;
      conv_code_q <= conv_code(conv_d);
    end
  end

  assign done_o            = done_q;
  assign tx_byte_o         = tx_q;
  assign tx_valid_o        = txv_q;
  assign readout_request_o = req_q;
  assign conversation_o    = conv_code_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_conv_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(conv_q))
    else $error("conversation state not one-hot");

  a_tx_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && tx_valid_o |-> conversation_o == CONV_CODE_READ)
    else $error("byte sent outside a read conversation");

  a_req_ends_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && readout_request_o |-> conversation_o == CONV_CODE_IDLE && !tx_valid_o)
    else $error("readout request without returning to idle");

  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !tx_valid_o |-> tx_byte_o == 8'h00)
    else $error("transmit byte not cleared when nothing is sent");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##2 done_o)
    else $error("accepted transaction produced no result");

endmodule
